// File: hw/rtl/twme_pkg.sv
// ----------------------------------------------------------------------------
// twme_pkg
// shared constants, codes and types of the two-run merge engine
// ----------------------------------------------------------------------------
`default_nettype none

package twme_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SPLIT_W = 11;
  localparam int unsigned CMP_W   = (SPLIT_W > CNT_W) ? SPLIT_W : CNT_W;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } seq_state_e;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/two_run_merge_engine_core.sv
// ----------------------------------------------------------------------------
// two_run_merge_engine_core
// two-way merge of two ascending runs held in one element store
//
// requests come in on the s_ channel: tuser selects load (0) or pop (1),
// tdata carries the signed 32-bit value of a load. the first split_point
// loaded values form the left run, the rest the right run. each pop yields
// the smaller run head on the m_ channel (left wins a tie), tlast marks the
// final element of the set. a pop with nothing left or a load past 1024
// entries is dropped; a load after popping starts a new set.
// a pop latches the heads when it is taken, then holds off the s_ channel
// while it does the registered read of both heads from the dual-read
// store and then the compare into the output register. split_point is
// written on the cfg channel while no request is in flight; the user must
// keep to this, as the block itself does not enforce it. reset clears the
// count, heads, split point and output valid flag; store contents and
// output data stay undefined until written. a stalled receiver holds the
// result; the next load is still taken, the next pop waits in its compare
// step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module two_run_merge_engine_core import twme_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_tvalid_i,
  output logic                          s_tready_o,
  input  wire logic signed [DATA_W-1:0] s_tdata_i,  // [31:0] value
  input  wire logic                     s_tuser_i,  // [0] command
  output logic                          m_tvalid_o,
  input  wire logic                     m_tready_i,
  output logic signed [DATA_W-1:0]      m_tdata_o,  // [31:0] merged_value
  output logic                          m_tlast_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [SPLIT_W-1:0]       cfg_data_i
);

  logic [SPLIT_W-1:0]       split_q;
  logic                     m_valid_q;
  logic signed [DATA_W-1:0] m_data_q;
  logic                     m_last_q;
  logic                     out_free;
  res_t                     res;

  assign out_free = !m_valid_q || m_tready_i;

  twme_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_tvalid_i),
    .req_ready_o(s_tready_o),
    .req_cmd_i  (cmd_e'(s_tuser_i)),
    .req_value_i(s_tdata_i),
    .split_i    (split_q),
    .out_free_i (out_free),
    .res_o      (res)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        split_q <= cfg_data_i;
      end
      if (res.valid) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      m_data_q <= res.value;
      m_last_q <= res.last;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/twme_ram.sv
// ----------------------------------------------------------------------------
// twme_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module twme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/twme_seq.sv
// ----------------------------------------------------------------------------
// twme_seq
// load/pop sequencer: element store, run heads and head compare
// ----------------------------------------------------------------------------
`default_nettype none

module twme_seq import twme_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     req_valid_i,
  output logic                          req_ready_o,
  input  wire cmd_e                     req_cmd_i,
  input  wire logic signed [DATA_W-1:0] req_value_i,
  input  wire logic [SPLIT_W-1:0]       split_i,
  input  wire logic                     out_free_i,
  output res_t                          res_o
);

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lh_q, lh_d;
  logic [CNT_W-1:0] rh_q, rh_d;
  logic [CNT_W-1:0] lend_q, lend_d;
  logic             merging_q, merging_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] rdata_l, rdata_r;

  logic [CNT_W-1:0] lend, base, lh_n, rh_n;
  logic             lav, rav, take_left;

  twme_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (req_value_i),
    .raddr_a_i(lh_q[ADDR_W-1:0]),
    .raddr_b_i(rh_q[ADDR_W-1:0]),
    .rdata_a_o(rdata_l),
    .rdata_b_o(rdata_r)
  );

  // left run end, saturated to the loaded count
  assign lend = (CMP_W'(split_i) < CMP_W'(cnt_q)) ? CNT_W'(split_i) : cnt_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lh_d        = lh_q;
    rh_d        = rh_q;
    lend_d      = lend_q;
    merging_d   = merging_q;
    we          = 1'b0;
    base        = merging_q ? '0 : cnt_q;
    waddr       = base[ADDR_W-1:0];
    lh_n        = merging_q ? lh_q : '0;
    rh_n        = merging_q ? rh_q : lend;
    lav         = lh_q < lend_q;
    rav         = rh_q < cnt_q;
    take_left   = 1'b0;
    req_ready_o = 1'b0;
    res_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_cmd_i == CMD_LOAD) begin
            merging_d = 1'b0;
            lh_d      = merging_q ? '0 : lh_q;
            rh_d      = merging_q ? '0 : rh_q;
            cnt_d     = base;
            if (CMP_W'(base) < CMP_W'(DEPTH)) begin
              we    = 1'b1;
              cnt_d = base + CNT_W'(1);
            end
          end else if (merging_q || (cnt_q != '0)) begin
            merging_d = 1'b1;
            lh_d      = lh_n;
            rh_d      = rh_n;
            lend_d    = lend;
            if ((lh_n < lend) || (rh_n < cnt_q)) begin
              state_d = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        take_left = lav && (!rav || ($signed(rdata_l) <= $signed(rdata_r)));
        if (out_free_i) begin
          res_o.valid = 1'b1;
          if (take_left) begin
            res_o.value = $signed(rdata_l);
            lh_d        = lh_q + CNT_W'(1);
          end else begin
            res_o.value = $signed(rdata_r);
            rh_d        = rh_q + CNT_W'(1);
          end
          res_o.last = (lh_d >= lend_q) && (rh_d >= cnt_q);
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      lh_q      <= '0;
      rh_q      <= '0;
      lend_q    <= '0;
      merging_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      lh_q      <= lh_d;
      rh_q      <= rh_d;
      lend_q    <= lend_d;
      merging_q <= merging_d;
    end
  end

endmodule

`default_nettype wire
